// ===== design/cns_pkg.sv =====
// ----------------------------------------------------------------------------
// Cross neighbour sum: shared package
// Widths, limits, configuration register codes and the structs that pass
// between the top level, the stencil stage and the result buffer.
// ----------------------------------------------------------------------------
package cns_pkg;

    // Default grid limits, handed to the top level as parameter defaults.
    localparam int CNS_MAX_COLS = 256;
    localparam int CNS_MAX_ROWS = 4096;

    // Field widths of the channels and of the configuration port.
    localparam int CNS_PIX_W      = 16;
    localparam int CNS_SUM_W      = 19;
    localparam int CNS_ROW_W      = 12;
    localparam int CNS_COL_W      = 8;
    localparam int CNS_CFG_W      = 13;
    localparam int CNS_COLS_REG_W = 9;
    localparam int CNS_IDX_W      = 1;

    // Register values after reset.
    localparam logic [CNS_CFG_W-1:0] CNS_ROWS_RESET = 13'd3;
    localparam logic [CNS_CFG_W-1:0] CNS_COLS_RESET = 13'd4;

    // Configuration register indexes.
    typedef enum logic [CNS_IDX_W-1:0] {
        CNS_REG_GRID_ROWS = 1'b0,
        CNS_REG_GRID_COLS = 1'b1
    } t_cfg_reg;

    // One-hot codes of the results that one sample can cause, in output order.
    localparam logic [2:0] CNS_RES_UP   = 3'b001;  // position one row up
    localparam logic [2:0] CNS_RES_LEFT = 3'b010;  // last row, one column left
    localparam logic [2:0] CNS_RES_FIN  = 3'b100;  // final grid position

    // A sample with its position and the edge flags the stencil needs.
    typedef struct packed {
        logic [CNS_PIX_W-1:0] pixel;
        logic [CNS_ROW_W-1:0] row;
        logic [CNS_ROW_W-1:0] row_up;
        logic [CNS_COL_W-1:0] col;
        logic [CNS_COL_W-1:0] col_left;
        logic                 has_up;
        logic                 has_up2;
        logic                 col_first;
        logic                 col_second;
        logic                 col_last;
        logic                 row_last;
    } t_item;

    // One result as it leaves the block.
    typedef struct packed {
        logic signed [CNS_SUM_W-1:0] neighbour_sum;
        logic [CNS_ROW_W-1:0]        out_row;
        logic [CNS_COL_W-1:0]        out_col;
        logic                        last_of_run;
        logic                        frame_end;
    } t_result;

    // Last valid index of a dimension after clamping to 2..maxv.
    function automatic int unsigned cns_last_idx(input logic [CNS_CFG_W-1:0] v,
                                                 input int unsigned maxv);
        int unsigned x;
        x = v;
        if (x < 2) begin
            return 1;
        end
        if (x > maxv) begin
            return maxv - 1;
        end
        return x - 1;
    endfunction

    // Sign extension of a sample to the width of a sum.
    function automatic logic [CNS_SUM_W-1:0] cns_sext(input logic [CNS_PIX_W-1:0] v);
        return {{(CNS_SUM_W-CNS_PIX_W){v[CNS_PIX_W-1]}}, v};
    endfunction

endpackage

// ===== design/cns_pix_if.sv =====
// ----------------------------------------------------------------------------
// Cross neighbour sum: sample channel
// Valid/ready channel that carries one grid sample per transfer.
// ----------------------------------------------------------------------------
interface cns_pix_if
    import cns_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic signed [CNS_PIX_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

// ===== design/cns_sum_if.sv =====
// ----------------------------------------------------------------------------
// Cross neighbour sum: result channel
// Valid/ready channel that carries one stencil sum and its position.
// ----------------------------------------------------------------------------
interface cns_sum_if
    import cns_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic signed [CNS_SUM_W-1:0] neighbour_sum;
    logic [CNS_ROW_W-1:0]        out_row;
    logic [CNS_COL_W-1:0]        out_col;
    logic                        last_of_run;
    logic                        frame_end;

    modport source (output valid, output neighbour_sum, output out_row, output out_col,
                    output last_of_run, output frame_end, input ready);
    modport sink   (input valid, input neighbour_sum, input out_row, input out_col,
                    input last_of_run, input frame_end, output ready);
endinterface

// ===== design/cross_neighbour_sum_top.sv =====
// ----------------------------------------------------------------------------
// Cross neighbour sum: top level
// Zero-padded five-point stencil sum over a raster stream of samples.
//
//   Channel   Dir  Transfer                Payload
//   i_pix     in   valid & ready           pixel_value
//   o_sum     out  valid & ready           neighbour_sum, out_row, out_col,
//                                          last_of_run, frame_end
//   i_cfg_*   in   i_cfg_we (no wait)      i_cfg_index, i_cfg_data
//
// A sample is taken every cycle while each sample causes at most one result
// and the result buffer has space. On the last row every sample after the first
// causes two results and the final sample three; the stencil stage hands
// out one result at a time, so the sample side then waits for each sample's
// last result to be handed over. Reset and register writes restart the
// frame at position (0,0); the line store is not cleared.
// A stalled result channel fills the two-entry result buffer, then holds the
// stencil stage and with it the sample channel.
// ----------------------------------------------------------------------------
module cross_neighbour_sum_top
    import cns_pkg::*;
#(
    parameter int MAX_COLS = CNS_MAX_COLS,
    parameter int MAX_ROWS = CNS_MAX_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cns_pix_if.sink              i_pix,
    cns_sum_if.source            o_sum,
    input  logic                 i_cfg_we,
    input  logic [CNS_IDX_W-1:0] i_cfg_index,
    input  logic [CNS_CFG_W-1:0] i_cfg_data
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int DEPTH = 3 * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);

    logic [RW-1:0] r_row,      n_row;
    logic [CW-1:0] r_col,      n_col;
    logic [1:0]    r_slot,     n_slot;
    logic [RW-1:0] r_row_last, n_row_last;
    logic [CW-1:0] r_col_last, n_col_last;

    logic          accept;
    logic          stage_ready;
    logic          can_load;
    logic          push;
    logic [1:0]    slot_m1;
    logic [1:0]    slot_m2;
    logic          col_is_last;
    logic          row_is_last;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
    logic [CNS_PIX_W-1:0] rd_a;
    logic [CNS_PIX_W-1:0] rd_b;
    t_item         item;
    t_result       result;

    assign i_pix.ready = stage_ready;
    assign accept      = i_pix.valid && stage_ready;
    assign col_is_last = (r_col == r_col_last);
    assign row_is_last = (r_row == r_row_last);

    // Line store slots of the two rows above the current one.
    always_comb begin
        slot_m1 = (r_slot == 2'd0) ? 2'd2 : r_slot - 2'd1;
        slot_m2 = (r_slot == 2'd2) ? 2'd0 : r_slot + 2'd1;
    end

    // Addresses. Port A fetches the sample up and right, or at the end of a
    // row the first sample of the current row for the next row's window.
    // No two accesses in one cycle touch the same entry.
    always_comb begin
        waddr   = AW'(r_slot) * AW'(MAX_COLS) + AW'(r_col);
        raddr_b = AW'(slot_m2) * AW'(MAX_COLS) + AW'(r_col);
        if (col_is_last) begin
            raddr_a = AW'(r_slot) * AW'(MAX_COLS);
        end else begin
            raddr_a = AW'(slot_m1) * AW'(MAX_COLS) + AW'(CW'(r_col + 1'b1));
        end
    end

    // Sample with its position and edge flags.
    always_comb begin
        item.pixel      = i_pix.pixel_value;
        item.row        = CNS_ROW_W'(r_row);
        item.row_up     = CNS_ROW_W'(RW'(r_row - 1'b1));
        item.col        = CNS_COL_W'(r_col);
        item.col_left   = CNS_COL_W'(CW'(r_col - 1'b1));
        item.has_up     = (r_row != '0);
        item.has_up2    = (r_row > RW'(1));
        item.col_first  = (r_col == '0);
        item.col_second = (r_col == CW'(1));
        item.col_last   = col_is_last;
        item.row_last   = row_is_last;
    end

    // Position counters and grid size; a register write restarts the frame.
    always_comb begin
        n_row      = r_row;
        n_col      = r_col;
        n_slot     = r_slot;
        n_row_last = r_row_last;
        n_col_last = r_col_last;
        if (i_cfg_we) begin
            n_row  = '0;
            n_col  = '0;
            n_slot = '0;
            unique case (t_cfg_reg'(i_cfg_index))
                CNS_REG_GRID_ROWS: begin
                    n_row_last = RW'(cns_last_idx(i_cfg_data, MAX_ROWS));
                end
                CNS_REG_GRID_COLS: begin
                    n_col_last = CW'(cns_last_idx(
                        CNS_CFG_W'(i_cfg_data[CNS_COLS_REG_W-1:0]), MAX_COLS));
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            if (col_is_last) begin
                n_col = '0;
                if (row_is_last) begin
                    n_row  = '0;
                    n_slot = '0;
                end else begin
                    n_row  = r_row + 1'b1;
                    n_slot = slot_m2;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_slot     <= '0;
            r_row_last <= RW'(cns_last_idx(CNS_ROWS_RESET, MAX_ROWS));
            r_col_last <= CW'(cns_last_idx(CNS_COLS_RESET, MAX_COLS));
        end else begin
            r_row      <= n_row;
            r_col      <= n_col;
            r_slot     <= n_slot;
            r_row_last <= n_row_last;
            r_col_last <= n_col_last;
        end
    end

    // Line store.
    cns_line_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_we      (accept),
        .i_waddr   (waddr),
        .i_wdata   (i_pix.pixel_value),
        .i_re      (accept),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // Stencil stage.
    cns_stencil u_stencil (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_item     (item),
        .i_rd_a     (rd_a),
        .i_rd_b     (rd_b),
        .i_can_load (can_load),
        .o_ready    (stage_ready),
        .o_push     (push),
        .o_result   (result)
    );

    // Result buffer.
    cns_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_result   (result),
        .o_can_load (can_load),
        .o_sum      (o_sum)
    );

endmodule

// ===== design/cns_line_store.sv =====
// ----------------------------------------------------------------------------
// Cross neighbour sum: line store
// Three rows of samples in one memory with one write port and two read
// ports. Read data is registered and holds until the next read.
// ----------------------------------------------------------------------------
module cns_line_store
    import cns_pkg::*;
#(
    parameter int DEPTH = 3 * CNS_MAX_COLS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [CNS_PIX_W-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr_a,
    input  logic [AW-1:0]        i_raddr_b,
    output logic [CNS_PIX_W-1:0] o_rdata_a,
    output logic [CNS_PIX_W-1:0] o_rdata_b
);

    logic [CNS_PIX_W-1:0] mem [DEPTH];
    logic [CNS_PIX_W-1:0] r_rd_a;
    logic [CNS_PIX_W-1:0] r_rd_b;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_a <= mem[i_raddr_a];
            r_rd_b <= mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

// ===== design/cns_stencil.sv =====
// ----------------------------------------------------------------------------
// Cross neighbour sum: stencil stage
// Holds one sample with the line store data read for it, keeps sliding
// windows over the current row and the row above, and hands out the up to
// three results the sample causes, one per cycle while the result buffer has space.
// ----------------------------------------------------------------------------
module cns_stencil
    import cns_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  t_item                i_item,
    input  logic [CNS_PIX_W-1:0] i_rd_a,
    input  logic [CNS_PIX_W-1:0] i_rd_b,
    input  logic                 i_can_load,
    output logic                 o_ready,
    output logic                 o_push,
    output t_result              o_result
);

    logic                 r_vld;
    t_item                r_item;
    logic [2:0]           r_done;
    logic [CNS_PIX_W-1:0] r_a_left;
    logic [CNS_PIX_W-1:0] r_a_mid;
    logic [CNS_PIX_W-1:0] r_c1;
    logic [CNS_PIX_W-1:0] r_c2;

    logic [2:0]           present;
    logic [2:0]           pending;
    logic [2:0]           sel;
    logic                 single;
    logic                 retire;
    logic [CNS_SUM_W-1:0] sum_up;
    logic [CNS_SUM_W-1:0] sum_left;
    logic [CNS_SUM_W-1:0] sum_fin;

    // Which results this sample causes and which are still to go.
    always_comb begin
        present = '0;
        present[0] = r_item.has_up;
        present[1] = r_item.row_last & ~r_item.col_first;
        present[2] = r_item.row_last & r_item.col_last;
        pending = present & ~r_done;
        sel     = pending & (~pending + 3'd1);
        single  = (pending != 3'd0) && (pending == sel);
    end

    // Sums of the three candidate positions; out-of-grid neighbours add zero.
    // The read port A data is the sample up and right, port B two rows up.
    always_comb begin
        sum_up = cns_sext(r_a_mid) + cns_sext(r_item.pixel)
               + (r_item.has_up2   ? cns_sext(i_rd_b)   : '0)
               + (r_item.col_first ? '0 : cns_sext(r_a_left))
               + (r_item.col_last  ? '0 : cns_sext(i_rd_a));
        sum_left = cns_sext(r_c1) + cns_sext(r_a_left) + cns_sext(r_item.pixel)
                 + ((r_item.col_first || r_item.col_second) ? '0 : cns_sext(r_c2));
        sum_fin = cns_sext(r_item.pixel) + cns_sext(r_a_mid) + cns_sext(r_c1);
    end

    // Result for the first pending position.
    always_comb begin
        o_result.last_of_run = single;
        o_result.frame_end   = 1'b0;
        case (sel)
            CNS_RES_LEFT: begin
                o_result.neighbour_sum = sum_left;
                o_result.out_row       = r_item.row;
                o_result.out_col       = r_item.col_left;
            end
            CNS_RES_FIN: begin
                o_result.neighbour_sum = sum_fin;
                o_result.out_row       = r_item.row;
                o_result.out_col       = r_item.col;
                o_result.frame_end     = 1'b1;
            end
            default: begin
                o_result.neighbour_sum = sum_up;
                o_result.out_row       = r_item.row_up;
                o_result.out_col       = r_item.col;
            end
        endcase
    end

    // The sample leaves once its last result has been handed over, or at once if it causes none.
    assign o_push  = r_vld && (pending != 3'd0) && i_can_load;
    assign retire  = r_vld && ((pending == 3'd0) || (i_can_load && single));
    assign o_ready = !r_vld || retire;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_done <= '0;
        end else begin
            if (i_load) begin
                r_vld <= 1'b1;
            end else if (retire) begin
                r_vld <= 1'b0;
            end
            if (retire) begin
                r_done <= '0;
            end else if (o_push) begin
                r_done <= r_done | sel;
            end
        end
    end

    // Sample register and windows. At the end of a row, port A returned the
    // first sample of this row, which becomes the upper centre of the next.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
        if (retire) begin
            r_a_left <= r_a_mid;
            r_a_mid  <= i_rd_a;
            r_c2     <= r_c1;
            r_c1     <= r_item.pixel;
        end
    end

endmodule

// ===== design/cns_out_buf.sv =====
// ----------------------------------------------------------------------------
// Cross neighbour sum: result buffer
// Two-entry buffer in front of the result channel. Its space flag comes from
// a register, so the result channel's ready never reaches the sample side.
// ----------------------------------------------------------------------------
module cns_out_buf
    import cns_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_result   i_result,
    output logic      o_can_load,
    cns_sum_if.source o_sum
);

    t_result    r_buf [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       pop;

    assign pop        = o_sum.valid && o_sum.ready;
    assign o_can_load = (r_cnt != 2'd2);

    // Fill level.
    always_comb begin
        case ({i_push, pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    // Pointers and level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= n_cnt;
        end
    end

    // Entries.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_result;
        end
    end

    // Channel drive.
    assign o_sum.valid         = (r_cnt != 2'd0);
    assign o_sum.neighbour_sum = r_buf[r_rd].neighbour_sum;
    assign o_sum.out_row       = r_buf[r_rd].out_row;
    assign o_sum.out_col       = r_buf[r_rd].out_col;
    assign o_sum.last_of_run   = r_buf[r_rd].last_of_run;
    assign o_sum.frame_end     = r_buf[r_rd].frame_end;

endmodule
